@@ sv/sem_pkg.sv @@
// shared types and constants for the sobel edge magnitude block
package sem_pkg;

  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int CH_W         = 8;
  localparam int NUM_CH       = 3;
  localparam int PIX_W        = CH_W * NUM_CH;
  localparam int FW_W         = 11;
  localparam int FH_W         = 13;
  localparam int ROW_W        = 12;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int GRAD_W       = 11;
  localparam int SQ_W         = 21;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int SQ_SAT       = 65280;

  localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_GRAD,
    S_SQUARE,
    S_ROOT,
    S_ROUND,
    S_OUT
  } state_t;

  typedef struct packed {
    logic       take;
    logic       shift;
    logic       grad;
    logic       square;
    logic       root_step;
    logic [2:0] root_bit;
    logic       round;
    logic       load;
  } cmd_t;

  typedef struct packed {
    logic produce;
    logic out_free;
  } status_t;

endpackage

@@ sv/sem_ctrl.sv @@
// controller state machine sequencing one beat through the datapath
module sem_ctrl
  import sem_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t     state, state_next;
  logic [2:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= 3'd7;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    cmd          = '0;
    cmd.root_bit = step;
    s_tready     = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.take   = 1'b1;
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = status.produce ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd.grad   = 1'b1;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        step_next  = 3'd7;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        step_next     = step - 3'd1;
        if (step == 3'd0) begin
          state_next = S_ROUND;
        end
      end
      S_ROUND: begin
        cmd.round  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ sv/sem_datapath.sv @@
// line store, 3x3 window, gradient, iterative root and output register
module sem_datapath
  import sem_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  op,
  input  logic [PIX_W-1:0]      pixel,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic                  m_tready,
  output logic                  m_tvalid,
  output logic [PIX_W-1:0]      m_tdata,
  output logic                  m_tlast
);

  logic [FW_W-1:0]  frame_width;
  logic [FH_W-1:0]  frame_height;
  logic [FW_W-1:0]  w_eff;
  logic [FH_W-1:0]  h_eff;
  logic [COL_W-1:0] w_last;
  logic [ROW_W-1:0] h_last;

  logic [COL_W-1:0] in_column;
  logic [1:0]       row_st;
  logic [ROW_W-1:0] crow;
  logic [COL_W-1:0] ccol;
  logic             produce;
  logic             restart;

  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd;
  logic [PIX_W-1:0]   x;

  logic [PIX_W-1:0] win [3][3];
  logic             row0_ok, row2_ok, col0_ok, col2_ok, last;
  logic [2:0]       rok, cok;

  logic [CH_W-1:0]          px   [NUM_CH][3][3];
  logic signed [GRAD_W-1:0] gx_c [NUM_CH];
  logic signed [GRAD_W-1:0] gy_c [NUM_CH];
  logic signed [GRAD_W-1:0] gx   [NUM_CH];
  logic signed [GRAD_W-1:0] gy   [NUM_CH];
  logic [SQ_W-1:0]          sq   [NUM_CH];
  logic [CH_W-1:0]          root [NUM_CH];
  logic [CH_W-1:0]          mag  [NUM_CH];

  always_comb begin
    if (frame_width == '0) begin
      w_eff = FW_W'(1);
    end else if (frame_width > FW_W'(MAX_WIDTH)) begin
      w_eff = FW_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = FH_W'(1);
    end else if (frame_height > FH_W'(HEIGHT_LIMIT)) begin
      h_eff = FH_W'(HEIGHT_LIMIT);
    end else begin
      h_eff = frame_height;
    end
  end

  assign w_last  = COL_W'(w_eff - FW_W'(1));
  assign h_last  = ROW_W'(h_eff - FH_W'(1));
  assign produce = (row_st == 2'd2) || ((row_st == 2'd1) && (in_column != '0));
  assign restart = cfg_we && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));

  assign status.produce  = produce;
  assign status.out_free = !m_tvalid || m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) begin
        frame_width <= cfg_data[FW_W-1:0];
      end
      if (cfg_index == CFG_HEIGHT) begin
        frame_height <= cfg_data[FH_W-1:0];
      end
    end
  end

  // line store: low half is the row above, high half two rows above
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      rd <= line_mem[in_column];
      x  <= op ? '0 : pixel;
    end
    if (cmd.shift) begin
      line_mem[in_column] <= {rd[PIX_W-1:0], x};
    end
  end

  // position counters and border masks
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_column <= '0;
      row_st    <= '0;
      crow      <= '0;
      ccol      <= '0;
      last      <= 1'b0;
    end else if (cmd.shift) begin
      if (in_column == w_last) begin
        in_column <= '0;
        if (row_st != 2'd2) begin
          row_st <= row_st + 2'd1;
        end
      end else begin
        in_column <= in_column + COL_W'(1);
      end
      if (produce) begin
        row0_ok <= crow != '0;
        row2_ok <= crow != h_last;
        col0_ok <= ccol != '0;
        col2_ok <= ccol != w_last;
        last    <= (ccol == w_last) && (crow == h_last);
        if ((ccol == w_last) && (crow == h_last)) begin
          in_column <= '0;
          row_st    <= '0;
          crow      <= '0;
          ccol      <= '0;
        end else if (ccol == w_last) begin
          ccol <= '0;
          crow <= crow + ROW_W'(1);
        end else begin
          ccol <= ccol + COL_W'(1);
        end
      end
    end
  end

  // 3x3 window, cleared on reset, on a restart and when a frame ends
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= rd[2*PIX_W-1:PIX_W];
      win[1][2] <= rd[PIX_W-1:0];
      win[2][2] <= x;
    end else if (cmd.grad && last) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end
  end

  assign rok = {row2_ok, 1'b1, row0_ok};
  assign cok = {col2_ok, 1'b1, col0_ok};

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          px[ch][r][c] = (rok[r] && cok[c]) ? win[r][c][ch*CH_W +: CH_W] : '0;
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      gx_c[ch] = $signed({1'b0, 10'({2'b0, px[ch][0][2]} + {1'b0, px[ch][1][2], 1'b0}
                                    + {2'b0, px[ch][2][2]})})
               - $signed({1'b0, 10'({2'b0, px[ch][0][0]} + {1'b0, px[ch][1][0], 1'b0}
                                    + {2'b0, px[ch][2][0]})});
      gy_c[ch] = $signed({1'b0, 10'({2'b0, px[ch][2][0]} + {1'b0, px[ch][2][1], 1'b0}
                                    + {2'b0, px[ch][2][2]})})
               - $signed({1'b0, 10'({2'b0, px[ch][0][0]} + {1'b0, px[ch][0][1], 1'b0}
                                    + {2'b0, px[ch][0][2]})});
    end
  end

  // gradient, square sum, one root bit per cycle, rounding
  always_ff @(posedge clk) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      logic signed [2*GRAD_W-1:0] gxx, gyy;
      logic [CH_W-1:0]            cand;
      logic [2*CH_W:0]            nsq;
      gxx  = gx[ch] * gx[ch];
      gyy  = gy[ch] * gy[ch];
      cand = root[ch] | (CH_W'(1) << cmd.root_bit);
      nsq  = (2*CH_W+1)'(root[ch] * root[ch]) + (2*CH_W+1)'(root[ch]);
      if (cmd.grad) begin
        gx[ch] <= gx_c[ch];
        gy[ch] <= gy_c[ch];
      end
      if (cmd.square) begin
        sq[ch]   <= SQ_W'(gxx) + SQ_W'(gyy);
        root[ch] <= '0;
      end
      if (cmd.root_step) begin
        if ((2*CH_W)'(cand * cand) <= sq[ch][2*CH_W-1:0]) begin
          root[ch] <= cand;
        end
      end
      if (cmd.round) begin
        if (sq[ch] > SQ_W'(SQ_SAT)) begin
          mag[ch] <= '1;
        end else if ((sq[ch][2*CH_W:0] > nsq) && (root[ch] != '1)) begin
          mag[ch] <= root[ch] + CH_W'(1);
        end else begin
          mag[ch] <= root[ch];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= {mag[2], mag[1], mag[0]};
      m_tlast <= last;
    end
  end

endmodule

@@ sv/sobel_edge_magnitude_rgb.sv @@
// top level of the rgb sobel edge magnitude block
//
// input beats arrive on s_* in raster order: tdata carries red, green,
// blue; tuser high marks a drain beat that acts as a zero pixel. results
// leave on m_*: tdata carries the red, green and blue magnitudes and tlast
// flags the last pixel of the frame. the result for pixel p leaves on the
// beat that carries pixel p + width + 1, so width + 1 drain beats after the
// frame flush the remaining results.
// a beat that gives no result reads the line store and shifts the window;
// a beat that gives a result then forms the gradient, the square sum, the
// bit-serial root and the rounding, and loads the output register; the
// load waits on any output stall.
// the next beat is taken while a finished result still waits in the output
// register; a stall on m_tready holds that result and stops the block only
// when the following result is ready.
// reset restores width 640 and height 480, clears the window and counters
// and empties the output register; the line store is not cleared.
// writes to the width or height on cfg_* take effect at once and restart the frame; other indices are ignored.
module sobel_edge_magnitude_rgb
  import sem_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
  input  logic                  s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [PIX_W-1:0]      m_tdata,   // red_mag, green_mag, blue_mag
  output logic                  m_tlast
);

  cmd_t    cmd;
  status_t status;

  sem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sem_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .op        (s_tuser),
    .pixel     (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

@@ sv/sem_checker.sv @@
// port checker for the sobel edge magnitude block, bound to the top level
module sem_checker
  import sem_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [PIX_W-1:0] m_tdata,
  input logic             m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_one_beat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second beat taken while one is in work");

  a_no_fast_result: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result right after a beat was taken");

endmodule

bind sobel_edge_magnitude_rgb sem_checker u_sem_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

@@ dv/sobel_checker.sv @@
// predicts rgb sobel magnitudes from observed beats and compares the results
`timescale 1ns / 1ps

module sobel_checker
  import sem_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [PIX_W-1:0]      s_tdata,   // red_in, green_in, blue_in
  input  logic                  s_tuser,   // op
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [PIX_W-1:0]      m_tdata,   // red_mag, green_mag, blue_mag
  input  logic                  m_tlast,
  output int                    pending,
  output int                    errors
);

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } mag_t;

  mag_t            mag_queue[$];
  int              width_reg, height_reg;
  logic [PIX_W-1:0] line_above[MAX_WIDTH];
  logic [PIX_W-1:0] line_above2[MAX_WIDTH];
  logic [PIX_W-1:0] win[3][3];
  int              col_pos, row_pos, done_count;

  function automatic void restart_frame();
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        win[i][j] = '0;
    col_pos = 0;
    row_pos = 0;
    done_count = 0;
  endfunction

  function automatic logic [CH_W-1:0] rounded_root(int s);
    int n, c;
    n = 0;
    if (s > SQ_SAT) return 8'd255;
    for (int b = 128; b != 0; b = b >> 1) begin
      c = n | b;
      if (c * c <= s) n = c;
    end
    if (s > n * n + n) n++;
    return (n > 255) ? 8'd255 : CH_W'(n);
  endfunction

  function automatic logic [CH_W-1:0] channel_magnitude(int sh, bit rok[3], bit cok[3]);
    int p[3][3];
    int gx, gy;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        p[i][j] = (rok[i] && cok[j]) ? int'((win[i][j] >> sh) & 24'hFF) : 0;
    gx = -p[0][0] + p[0][2] - 2 * p[1][0] + 2 * p[1][2] - p[2][0] + p[2][2];
    gy = -p[0][0] - 2 * p[0][1] - p[0][2] + p[2][0] + 2 * p[2][1] + p[2][2];
    return rounded_root(gx * gx + gy * gy);
  endfunction

  function automatic void take_pixel(logic drain, logic [PIX_W-1:0] pix);
    int w, h, c, crow, ccol;
    longint t;
    logic [PIX_W-1:0] x, a1, a2;
    bit rok[3], cok[3];
    mag_t m;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > HEIGHT_LIMIT ? HEIGHT_LIMIT : height_reg);
    x = drain ? '0 : pix;
    c = col_pos % w;
    a1 = line_above[c];
    a2 = line_above2[c];
    line_above2[c] = a1;
    line_above[c] = x;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = a2;
    win[1][2] = a1;
    win[2][2] = x;
    t = longint'(row_pos) * w + c;
    c++;
    if (c >= w) begin
      c = 0;
      row_pos++;
    end
    col_pos = c;
    if (t >= w + 1 && done_count < w * h) begin
      crow = done_count / w;
      ccol = done_count % w;
      rok[0] = crow != 0;
      rok[1] = 1;
      rok[2] = crow != h - 1;
      cok[0] = ccol != 0;
      cok[1] = 1;
      cok[2] = ccol != w - 1;
      m.red = channel_magnitude(0, rok, cok);
      m.green = channel_magnitude(8, rok, cok);
      m.blue = channel_magnitude(16, rok, cok);
      m.last = (done_count == w * h - 1);
      mag_queue.push_back(m);
      done_count++;
      if (m.last) restart_frame();
    end
  endfunction

  initial begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      line_above[i] = '0;
      line_above2[i] = '0;
    end
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    mag_t m;
    if (rst) begin
      width_reg = 640;
      height_reg = 480;
      restart_frame();
      mag_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH) begin
          width_reg = int'(cfg_data[FW_W-1:0]);
          restart_frame();
        end else if (cfg_index == CFG_HEIGHT) begin
          height_reg = int'(cfg_data);
          restart_frame();
        end
      end
      if (m_tvalid && m_tready) begin
        if (mag_queue.size() == 0) begin
          $error("unexpected result beat: tdata %h tlast %b", m_tdata, m_tlast);
          errors = errors + 1;
        end else begin
          m = mag_queue.pop_front();
          if (m_tdata[7:0] !== m.red) begin
            $error("red_mag expected %0d actual %0d", m.red, m_tdata[7:0]);
            errors = errors + 1;
          end
          if (m_tdata[15:8] !== m.green) begin
            $error("green_mag expected %0d actual %0d", m.green, m_tdata[15:8]);
            errors = errors + 1;
          end
          if (m_tdata[23:16] !== m.blue) begin
            $error("blue_mag expected %0d actual %0d", m.blue, m_tdata[23:16]);
            errors = errors + 1;
          end
          if (m_tlast !== m.last) begin
            $error("frame_last expected %0d actual %0d", m.last, m_tlast);
            errors = errors + 1;
          end
        end
      end
      if (s_tvalid && s_tready) take_pixel(s_tuser, s_tdata);
    end
    pending <= mag_queue.size();
  end

endmodule

@@ dv/testbench.sv @@
// stimulus and verdict for the rgb sobel edge magnitude block
`timescale 1ns / 1ps

module testbench;
  import sem_pkg::*;

  localparam int NUM_BEATS   = 1150;
  localparam int SETTLE      = 40;
  localparam int CYCLE_LIMIT = 2000000;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  cfg_we = 0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 0;
  logic                  s_tready;
  logic [PIX_W-1:0]      s_tdata = '0;
  logic                  s_tuser = 0;
  logic                  m_tvalid;
  logic                  m_tready = 0;
  logic [PIX_W-1:0]      m_tdata;
  logic                  m_tlast;
  int                    pending, errors;
  int                    cycles = 0;
  int                    send_idle_pct = 0;
  int                    stall_pct = 0;
  int                    beats = 0;

  always #1 clk = ~clk;

  sobel_edge_magnitude_rgb uut (.*);

  sobel_checker u_checker (.*);

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_beat(logic drain, logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= drain;
    s_tdata <= pix;
    do @(posedge clk); while (!s_tready);
    beats++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    wait_idle();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [PIX_W-1:0] random_pixel(int mode);
    logic [PIX_W-1:0] p;
    p = PIX_W'($urandom);
    if (mode == 1)
      for (int i = 0; i < PIX_W; i += CH_W)
        p[i +: CH_W] = $urandom_range(1) ? 8'hFF : 8'h00;
    return p;
  endfunction

  initial begin
    int w, h, n, mode;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // 3x3 checkerboard of extremes with a pause mid-frame
    write_reg(CFG_WIDTH, 3);
    write_reg(CFG_HEIGHT, 3);
    for (int i = 0; i < 9; i++) begin
      send_beat(1'b0, (i % 2) ? 24'hFFFFFF : 24'h000000);
      if (i == 4) wait_idle();
    end
    for (int i = 0; i < 4; i++) send_beat(1'b1, PIX_W'($urandom));
    // drain with no frame in progress starts a new frame
    send_beat(1'b1, 24'hFFFFFF);
    // zero registers act as one
    write_reg(CFG_WIDTH, 0);
    write_reg(CFG_HEIGHT, 0);
    send_beat(1'b0, 24'hFF00FF);
    send_beat(1'b1, 24'h0);
    send_beat(1'b1, 24'h0);
    // oversize width and height clamp
    write_reg(CFG_WIDTH, 2047);
    write_reg(CFG_HEIGHT, 8191);
    for (int i = 0; i < 3; i++) send_beat(1'b0, 24'hFFFFFF);
    write_reg(CFG_WIDTH, MAX_WIDTH);
    write_reg(CFG_HEIGHT, HEIGHT_LIMIT);
    write_reg(CFG_IDX_W'(2), 5);
    write_reg(CFG_IDX_W'(3), 8191);
    write_reg(CFG_WIDTH, 1);
    for (int i = 0; i < 5; i++) send_beat(1'b0, 24'hFFFFFF);

    while (beats < NUM_BEATS) begin
      case (beats * 4 / NUM_BEATS)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 59; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 59; end
        default: begin send_idle_pct = 33; stall_pct = 33; end
      endcase
      w = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      if ($urandom_range(7) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 3)), int'($urandom));
      write_reg(CFG_WIDTH, w);
      write_reg(CFG_HEIGHT, h);
      mode = $urandom_range(2);
      n = w * h;
      if ($urandom_range(9) == 0) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(29) == 0) send_beat(1'b1, PIX_W'($urandom));
        else send_beat(1'b0, random_pixel(mode));
      end
      n = w + 1;
      if ($urandom_range(9) == 0) n = n + $urandom_range(1, 3);
      for (int i = 0; i < n; i++) send_beat(1'b1, PIX_W'($urandom));
    end

    wait_idle();
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
sv/sem_pkg.sv
sv/sem_ctrl.sv
sv/sem_datapath.sv
sv/sobel_edge_magnitude_rgb.sv
sv/sem_checker.sv
dv/sobel_checker.sv
dv/testbench.sv
